// ===== hdl/dlkc_pkg.sv =====
// ----------------------------------------------------------------------------
// dlkc_pkg
// Shared types and constants of the dual lru key cache unit.
// ----------------------------------------------------------------------------
package dlkc_pkg;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned IDX_W       = $clog2(DEPTH);
  localparam int unsigned TAG_BITS    = 64;
  localparam int unsigned HANDLE_BITS = 32;
  localparam int unsigned STAMP_W     = 64;
  localparam int unsigned STAT_W      = 32;
  localparam int unsigned LIM_W       = 7;
  localparam int unsigned OCC_W       = 7;
  localparam int unsigned WORD_W      = TAG_BITS + HANDLE_BITS + STAMP_W;

  // operation codes
  typedef enum logic [1:0] {
    OP_GET_EXACT  = 2'd0,
    OP_GET_STRUCT = 2'd1,
    OP_PUT_BOTH   = 2'd2,
    OP_PUT_EXACT  = 2'd3
  } op_e;

  // table select, also the top address bit of the entry memory
  localparam logic TBL_EXACT  = 1'b0;
  localparam logic TBL_STRUCT = 1'b1;

  // configuration register indexes
  localparam logic CFG_EXACT_LIMIT  = 1'b0;
  localparam logic CFG_STRUCT_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_DONE
  } state_e;

  // entry word: tag, handle, stamp
  typedef struct packed {
    logic [TAG_BITS-1:0]    tag;
    logic [HANDLE_BITS-1:0] handle;
    logic [STAMP_W-1:0]     stamp;
  } entry_t;

endpackage

// ===== hdl/dual_lru_key_cache_unit.sv =====
// ----------------------------------------------------------------------------
// dual_lru_key_cache_unit
// Exact and structural key-to-handle tables with shared use stamps and
// oldest-stamp replacement, held in one synchronous entry memory.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | sink      | in_valid_i/in_ready_o  | op, lookup_key, second_key, value
//  out     | source    | out_valid_o/out_ready_i| hit, found_value, evicted, counts
//  cfg     | sink      | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
//  each table pass reads all DEPTH entries through the one memory read port,
//  then drains the last returned entry and commits; a put to both tables makes
//  an exact pass and then a structural pass before the result is loaded.
//  reset clears valid bits, use counter, statistics and limits at once; no sweep.
//  the next beat is taken while a result still waits in the output register;
//  a stalled output holds the block only when the next result is ready.
module dual_lru_key_cache_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       op_i,
  input  logic [63:0]                      lookup_key_i,
  input  logic [63:0]                      second_key_i,
  input  logic [31:0]                      value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             hit_o,
  output logic [31:0]                      found_value_o,
  output logic [1:0]                       evicted_o,
  output logic [31:0]                      exact_hit_count_o,
  output logic [31:0]                      exact_miss_count_o,
  output logic [31:0]                      structural_hit_count_o,
  output logic [31:0]                      exact_eviction_count_o,
  output logic [31:0]                      structural_eviction_count_o,
  output logic [6:0]                       exact_occupancy_o,
  output logic [6:0]                       structural_occupancy_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_index_i,
  input  logic [6:0]                       cfg_data_i
);

  dlkc_pkg::state_e state_q, state_d;

  // item registers
  dlkc_pkg::op_e                      op_q;
  logic [dlkc_pkg::TAG_BITS-1:0]      key_q;
  logic [dlkc_pkg::TAG_BITS-1:0]      key2_q;
  logic [dlkc_pkg::HANDLE_BITS-1:0]   data_q;
  logic                               tbl_q;

  // scan registers
  logic [dlkc_pkg::IDX_W-1:0]         scan_idx_q;
  logic                               p_vld_q;
  logic [dlkc_pkg::IDX_W-1:0]         p_idx_q;
  dlkc_pkg::entry_t                   rdata_q;
  logic                               m_found_q, f_found_q, v_found_q;
  logic [dlkc_pkg::IDX_W-1:0]         m_idx_q, f_idx_q, v_idx_q;
  logic [dlkc_pkg::HANDLE_BITS-1:0]   m_handle_q;
  logic [dlkc_pkg::STAMP_W-1:0]       v_stamp_q;

  // architectural state
  logic [1:0][dlkc_pkg::DEPTH-1:0]    vld_q;
  logic [dlkc_pkg::STAMP_W-1:0]       use_cnt_q;
  logic [dlkc_pkg::STAT_W-1:0]        ex_hit_q, ex_miss_q, st_hit_q, ex_ev_q, st_ev_q;
  logic [1:0][dlkc_pkg::OCC_W-1:0]    occ_q;
  logic [1:0][dlkc_pkg::LIM_W-1:0]    lim_q;

  // per-item result
  logic                               hit_q;
  logic [dlkc_pkg::HANDLE_BITS-1:0]   found_q;
  logic [1:0]                         ev_q;

  // output register
  logic                               out_valid_q;
  logic                               o_hit_q;
  logic [31:0]                        o_found_q;
  logic [1:0]                         o_ev_q;
  logic [31:0]                        o_c0_q, o_c1_q, o_c2_q, o_c3_q, o_c4_q;
  logic [6:0]                         o_occ0_q, o_occ1_q;

  // memory
  dlkc_pkg::entry_t                   mem_q [2*dlkc_pkg::DEPTH];

  logic in_acc, rd_en, commit_en, load_out, last_idx;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dlkc_pkg::ST_IDLE:   if (in_acc) state_d = dlkc_pkg::ST_SCAN;
      dlkc_pkg::ST_SCAN:   if (last_idx) state_d = dlkc_pkg::ST_DRAIN;
      dlkc_pkg::ST_DRAIN:  state_d = dlkc_pkg::ST_COMMIT;
      dlkc_pkg::ST_COMMIT: begin
        if (op_q == dlkc_pkg::OP_PUT_BOTH && tbl_q == dlkc_pkg::TBL_EXACT) begin
          state_d = dlkc_pkg::ST_SCAN;
        end else begin
          state_d = dlkc_pkg::ST_DONE;
        end
      end
      dlkc_pkg::ST_DONE:   if (load_out) state_d = dlkc_pkg::ST_IDLE;
      default:             state_d = dlkc_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = (state_q == dlkc_pkg::ST_IDLE);
    rd_en      = (state_q == dlkc_pkg::ST_SCAN);
    commit_en  = (state_q == dlkc_pkg::ST_COMMIT);
    load_out   = (state_q == dlkc_pkg::ST_DONE) && (!out_valid_q || out_ready_i);
  end

  assign in_acc      = in_valid_i && in_ready_o;
  assign last_idx    = (scan_idx_q == dlkc_pkg::IDX_W'(dlkc_pkg::DEPTH - 1));
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dlkc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // commit decisions
  logic                             is_put, cur_v, do_evict, full;
  logic [dlkc_pkg::OCC_W-1:0]       eff_lim, cur_occ;
  logic [dlkc_pkg::IDX_W-1:0]       slot;
  logic                             we;
  logic [dlkc_pkg::IDX_W-1:0]       widx;
  dlkc_pkg::entry_t                 wdata;
  logic [dlkc_pkg::TAG_BITS-1:0]    cur_key;

  always_comb begin
    is_put  = op_q[1];
    cur_key = key_q;
    cur_occ = occ_q[tbl_q];
    if (lim_q[tbl_q] == '0 || lim_q[tbl_q] > dlkc_pkg::LIM_W'(dlkc_pkg::DEPTH)) begin
      eff_lim = dlkc_pkg::OCC_W'(dlkc_pkg::DEPTH);
    end else begin
      eff_lim = lim_q[tbl_q];
    end
    full     = (cur_occ >= eff_lim);
    do_evict = is_put && !m_found_q && full && v_found_q;
    if (do_evict && (!f_found_q || v_idx_q < f_idx_q)) begin
      slot = v_idx_q;
    end else begin
      slot = f_idx_q;
    end
    we           = 1'b0;
    widx         = slot;
    wdata.tag    = cur_key;
    wdata.handle = data_q;
    wdata.stamp  = use_cnt_q;
    if (commit_en) begin
      if (m_found_q) begin
        we   = 1'b1;
        widx = m_idx_q;
        if (!is_put) wdata.handle = m_handle_q;
      end else if (is_put) begin
        we = 1'b1;
      end
    end
    cur_v = vld_q[tbl_q][p_idx_q];
  end

  // entry memory
  always_ff @(posedge clk_i) begin
    if (we) mem_q[{tbl_q, widx}] <= wdata;
    if (rd_en) rdata_q <= mem_q[{tbl_q, scan_idx_q}];
  end

  // scan, commit and state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      use_cnt_q  <= '0;
      ex_hit_q   <= '0;
      ex_miss_q  <= '0;
      st_hit_q   <= '0;
      ex_ev_q    <= '0;
      st_ev_q    <= '0;
      occ_q      <= '0;
      lim_q      <= '0;
      p_vld_q    <= 1'b0;
      p_idx_q    <= '0;
      scan_idx_q <= '0;
      m_found_q  <= 1'b0;
      f_found_q  <= 1'b0;
      v_found_q  <= 1'b0;
      m_idx_q    <= '0;
      f_idx_q    <= '0;
      v_idx_q    <= '0;
      m_handle_q <= '0;
      v_stamp_q  <= '0;
    end else begin
      // configuration writes
      if (cfg_valid_i) begin
        if (cfg_index_i == dlkc_pkg::CFG_EXACT_LIMIT) lim_q[dlkc_pkg::TBL_EXACT] <= cfg_data_i;
        else lim_q[dlkc_pkg::TBL_STRUCT] <= cfg_data_i;
      end
      // read pipeline
      p_vld_q <= rd_en;
      p_idx_q <= scan_idx_q;
      if (rd_en) scan_idx_q <= scan_idx_q + 1'b1;
      // examine one returned entry
      if (p_vld_q) begin
        if (cur_v && rdata_q.tag == key_q && !m_found_q) begin
          m_found_q  <= 1'b1;
          m_idx_q    <= p_idx_q;
          m_handle_q <= rdata_q.handle;
        end
        if (!cur_v && !f_found_q) begin
          f_found_q <= 1'b1;
          f_idx_q   <= p_idx_q;
        end
        if (cur_v && (!v_found_q || rdata_q.stamp < v_stamp_q)) begin
          v_found_q <= 1'b1;
          v_idx_q   <= p_idx_q;
          v_stamp_q <= rdata_q.stamp;
        end
      end
      // commit one table
      if (commit_en) begin
        m_found_q <= 1'b0;
        f_found_q <= 1'b0;
        v_found_q <= 1'b0;
        if (is_put) begin
          use_cnt_q <= use_cnt_q + 1'b1;
          if (!m_found_q) begin
            if (do_evict) begin
              vld_q[tbl_q][v_idx_q] <= 1'b0;
              if (tbl_q == dlkc_pkg::TBL_EXACT) ex_ev_q <= ex_ev_q + 1'b1;
              else st_ev_q <= st_ev_q + 1'b1;
            end else begin
              occ_q[tbl_q] <= cur_occ + 1'b1;
            end
            vld_q[tbl_q][slot] <= 1'b1;
          end
        end else if (m_found_q) begin
          use_cnt_q <= use_cnt_q + 1'b1;
          if (tbl_q == dlkc_pkg::TBL_EXACT) ex_hit_q <= ex_hit_q + 1'b1;
          else st_hit_q <= st_hit_q + 1'b1;
        end else if (tbl_q == dlkc_pkg::TBL_EXACT) begin
          ex_miss_q <= ex_miss_q + 1'b1;
        end
      end
    end
  end

  // item registers and per-item result
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= dlkc_pkg::op_e'(op_i);
      key_q   <= lookup_key_i[dlkc_pkg::TAG_BITS-1:0];
      key2_q  <= second_key_i[dlkc_pkg::TAG_BITS-1:0];
      data_q  <= value_i[dlkc_pkg::HANDLE_BITS-1:0];
      tbl_q   <= (dlkc_pkg::op_e'(op_i) == dlkc_pkg::OP_GET_STRUCT) ?
                 dlkc_pkg::TBL_STRUCT : dlkc_pkg::TBL_EXACT;
      hit_q   <= 1'b0;
      found_q <= '0;
      ev_q    <= '0;
    end
    if (commit_en) begin
      if (!is_put && m_found_q) begin
        hit_q   <= 1'b1;
        found_q <= m_handle_q;
      end
      if (do_evict) ev_q <= ev_q + 1'b1;
      // second pass goes to the structural table
      if (op_q == dlkc_pkg::OP_PUT_BOTH && tbl_q == dlkc_pkg::TBL_EXACT) begin
        tbl_q <= dlkc_pkg::TBL_STRUCT;
        key_q <= key2_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      o_hit_q   <= hit_q;
      o_found_q <= found_q;
      o_ev_q    <= ev_q;
      o_c0_q    <= ex_hit_q;
      o_c1_q    <= ex_miss_q;
      o_c2_q    <= st_hit_q;
      o_c3_q    <= ex_ev_q;
      o_c4_q    <= st_ev_q;
      o_occ0_q  <= occ_q[dlkc_pkg::TBL_EXACT];
      o_occ1_q  <= occ_q[dlkc_pkg::TBL_STRUCT];
    end
  end

  assign out_valid_o                 = out_valid_q;
  assign hit_o                       = o_hit_q;
  assign found_value_o               = o_found_q;
  assign evicted_o                   = o_ev_q;
  assign exact_hit_count_o           = o_c0_q;
  assign exact_miss_count_o          = o_c1_q;
  assign structural_hit_count_o      = o_c2_q;
  assign exact_eviction_count_o      = o_c3_q;
  assign structural_eviction_count_o = o_c4_q;
  assign exact_occupancy_o           = o_occ0_q;
  assign structural_occupancy_o      = o_occ1_q;

endmodule
